// ===== rtl/mono_note_priority_stack_defines.svh =====
// Assertion macros used by the checker file of the note priority stack.
// Depends on signals clk and arst_n being visible where a macro is used.
`ifndef MONO_NOTE_PRIORITY_STACK_DEFINES_SVH
`define MONO_NOTE_PRIORITY_STACK_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MNPS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mnps check failed");

// Next-cycle implication, disabled during reset
`define MNPS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mnps check failed");

`endif

// ===== rtl/mnps_pkg.sv =====
// Shared types and constants of the mono note priority stack.
// No dependencies; every other source file but the defines header imports this package.
package mnps_pkg;

	localparam int HELD_DEPTH_DEF     = 16;
	localparam int DEFERRED_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH        = 2;

	localparam int KIND_W      = 2;
	localparam int CH_W        = 4;
	localparam int NOTE_W      = 7;
	localparam int VEL_W       = 7;
	localparam int CMD_W       = 3;
	localparam int CFG_INDEX_W = 2;

	localparam logic [VEL_W-1:0] RETURN_VELOCITY = 7'd102;

	// input event kinds
	localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PEDAL    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MONO_ENABLE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LEGATO_ENABLE = 2'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_START    = 3'd0,
		CMD_GLIDE    = 3'd1,
		CMD_RELEASE  = 3'd2,
		CMD_POLY_ON  = 3'd3,
		CMD_POLY_OFF = 3'd4,
		CMD_ALL_OFF  = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		OP_NOTE_ON,
		OP_NOTE_OFF,
		OP_PEDAL_DOWN,
		OP_PEDAL_UP,
		OP_ALL_OFF
	} op_kind_t;

	// classified event, as queued between front and back
	typedef struct packed {
		op_kind_t          op;
		logic              mono;
		logic              legato;
		logic [CH_W-1:0]   channel;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  velocity;
		logic              tail;
	} op_t;

	// one voice command word
	typedef struct packed {
		cmd_t              command;
		logic [CH_W-1:0]   channel;
		logic [NOTE_W-1:0] target;
		logic [VEL_W-1:0]  velocity;
		logic [NOTE_W-1:0] glide_from;
		logic              glide_from_valid;
		logic              same_note;
		logic              release_tail;
		logic              last;
	} res_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ON_EMIT,
		ST_ON_PREP,
		ST_SHIFT,
		ST_DEC,
		ST_APPEND,
		ST_OFF_CHECK,
		ST_D_SRCH,
		ST_D_APPEND,
		ST_OFF_START,
		ST_SRCH,
		ST_OFF_TOP,
		ST_OFF_RET,
		ST_OFF_EMIT,
		ST_RPL_RD,
		ST_RPL_WAIT,
		ST_ALL_EMIT
	} back_state_t;

endpackage

// ===== rtl/mono_note_priority_stack.sv =====
// Order of work: a note on issues its command through the output register; a note off
// searches and compacts the stack, one entry a cycle; a pedal release in mono mode replays
// each deferred note-off in turn. Throughput: one event at a time in the back sequencer; a
// note on with a full stack first shifts out the oldest entry; output stalls hold the
// sequencer, and a two-word queue decouples the input.
// Reset: asynchronous, clears counts, pedal, previous note and handshakes; stores stay as is.
module mono_note_priority_stack #(
	parameter int HELD_DEPTH     = mnps_pkg::HELD_DEPTH_DEF,
	parameter int DEFERRED_DEPTH = mnps_pkg::DEFERRED_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mnps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic                             cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [mnps_pkg::KIND_W-1:0]      kind,
	input  logic [mnps_pkg::CH_W-1:0]        channel,
	input  logic [mnps_pkg::NOTE_W-1:0]      note,
	input  logic [mnps_pkg::VEL_W-1:0]       velocity,
	input  logic                             tail_off,
	input  logic                             pedal_down,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mnps_pkg::CMD_W-1:0]       command,
	output logic [mnps_pkg::CH_W-1:0]        out_channel,
	output logic [mnps_pkg::NOTE_W-1:0]      target_note,
	output logic [mnps_pkg::VEL_W-1:0]       out_velocity,
	output logic [mnps_pkg::NOTE_W-1:0]      glide_from_note,
	output logic                             glide_from_valid,
	output logic                             same_note,
	output logic                             release_tail,
	output logic                             last
);
	import mnps_pkg::*;

	logic op_in_valid, op_in_ready, op_out_valid, op_out_ready;
	op_t  op_in, op_out;
	res_t res;

	// classify events and hold configuration
	mnps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.channel    (channel),
		.note       (note),
		.velocity   (velocity),
		.tail_off   (tail_off),
		.pedal_down (pedal_down),
		.op_valid   (op_in_valid),
		.op_ready   (op_in_ready),
		.op         (op_in)
	);

	// decouple front from back
	mnps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (op_in_valid),
		.push_ready (op_in_ready),
		.push_data  (op_in),
		.pop_valid  (op_out_valid),
		.pop_ready  (op_out_ready),
		.pop_data   (op_out)
	);

	// run note stack operations and issue commands
	mnps_back #(
		.HELD_DEPTH     (HELD_DEPTH),
		.DEFERRED_DEPTH (DEFERRED_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_out_valid),
		.op_ready  (op_out_ready),
		.op        (op_out),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign command          = res.command;
	assign out_channel      = res.channel;
	assign target_note      = res.target;
	assign out_velocity     = res.velocity;
	assign glide_from_note  = res.glide_from;
	assign glide_from_valid = res.glide_from_valid;
	assign same_note        = res.same_note;
	assign release_tail     = res.release_tail;
	assign last             = res.last;

endmodule

// ===== rtl/mnps_front.sv =====
// Front end: configuration registers and event classification.
// Depends on mnps_pkg; feeds classified words into mnps_queue.
module mnps_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mnps_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic                              cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mnps_pkg::KIND_W-1:0]       kind,
	input  logic [mnps_pkg::CH_W-1:0]         channel,
	input  logic [mnps_pkg::NOTE_W-1:0]       note,
	input  logic [mnps_pkg::VEL_W-1:0]        velocity,
	input  logic                              tail_off,
	input  logic                              pedal_down,
	output logic                              op_valid,
	input  logic                              op_ready,
	output mnps_pkg::op_t                     op
);
	import mnps_pkg::*;

	logic mono_q;
	logic legato_q;

	// take register writes at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mono_q   <= 1'b0;
			legato_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MONO_ENABLE:   mono_q   <= cfg_data;
				REG_LEGATO_ENABLE: legato_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pass the handshake straight to the queue
	assign op_valid = in_valid;
	assign in_ready = op_ready;

	// classify the event and tag it with the current mode
	always_comb begin
		op.mono     = mono_q;
		op.legato   = legato_q;
		op.channel  = channel;
		op.note     = note;
		op.velocity = velocity;
		op.tail     = tail_off;
		case (kind)
			KIND_NOTE_ON:  op.op = OP_NOTE_ON;
			KIND_NOTE_OFF: op.op = OP_NOTE_OFF;
			KIND_PEDAL:    op.op = pedal_down ? OP_PEDAL_DOWN : OP_PEDAL_UP;
			default:       op.op = OP_ALL_OFF;
		endcase
	end

endmodule

// ===== rtl/mnps_queue.sv =====
// Short queue of classified words between front and back.
// Depends on mnps_pkg for the word type and depth.
module mnps_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  mnps_pkg::op_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output mnps_pkg::op_t pop_data
);
	import mnps_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slot_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// store the incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/mnps_back.sv =====
// Back end: sequencer over the held-note stack and deferred note-off list,
// with the command output register. Depends on mnps_pkg.
module mnps_back #(
	parameter int HELD_DEPTH     = mnps_pkg::HELD_DEPTH_DEF,
	parameter int DEFERRED_DEPTH = mnps_pkg::DEFERRED_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	output logic           op_ready,
	input  mnps_pkg::op_t  op,
	output logic           out_valid,
	input  logic           out_ready,
	output mnps_pkg::res_t res
);
	import mnps_pkg::*;

	localparam int HIW = $clog2(HELD_DEPTH);
	localparam int HCW = $clog2(HELD_DEPTH + 1);
	localparam int DIW = $clog2(DEFERRED_DEPTH);
	localparam int DCW = $clog2(DEFERRED_DEPTH + 1);

	back_state_t       state_q, state_d;
	op_t               op_q;
	logic [NOTE_W-1:0] cur_note_q;
	logic [VEL_W-1:0]  cur_vel_q;
	logic              cur_tail_q;
	logic              on_ctx_q;
	logic              replay_q;
	logic [HIW-1:0]    j_q;
	logic [DIW-1:0]    dj_q;
	logic [DIW-1:0]    r_q;
	logic [DCW-1:0]    rcnt_q;
	logic [HCW-1:0]    hcnt_q;
	logic [DCW-1:0]    dcnt_q;
	logic              pedal_q;
	logic [NOTE_W-1:0] prev_note_q;
	logic              prev_valid_q;
	res_t              out_q;
	logic              out_valid_q;

	logic [NOTE_W-1:0] held_mem [HELD_DEPTH];
	logic [NOTE_W-1:0] h_rdata_q;
	logic [NOTE_W-1:0] def_mem [DEFERRED_DEPTH];
	logic [NOTE_W-1:0] d_rdata_q;

	logic              h_re, h_we, d_re, d_we;
	logic [HIW-1:0]    h_raddr, h_waddr;
	logic [NOTE_W-1:0] h_wdata;
	logic [DIW-1:0]    d_raddr, d_waddr;
	logic              emit_en;
	res_t              emit_res;

	logic              slot_free;
	logic [HCW-1:0]    h_j1, h_j2;
	logic [DCW-1:0]    d_j1, r_1;
	logic              j_top, j_last_shift, h_hit;
	logic              dj_top, d_hit;
	logic              same_on, rpl_more, last_flag, held_full;
	logic [VEL_W-1:0]  ret_vel;

	// shared conditions
	assign slot_free    = !out_valid_q || out_ready;
	assign h_j1         = HCW'(j_q) + HCW'(1);
	assign h_j2         = HCW'(j_q) + HCW'(2);
	assign j_top        = (h_j1 == hcnt_q);
	assign j_last_shift = (h_j2 == hcnt_q);
	assign h_hit        = (h_rdata_q == cur_note_q);
	assign d_j1         = DCW'(dj_q) + DCW'(1);
	assign dj_top       = (d_j1 == dcnt_q);
	assign d_hit        = (d_rdata_q == cur_note_q);
	assign r_1          = DCW'(r_q) + DCW'(1);
	assign rpl_more     = replay_q && (r_1 != rcnt_q);
	assign last_flag    = !rpl_more;
	assign same_on      = prev_valid_q && (cur_note_q == prev_note_q);
	assign held_full    = (hcnt_q == HCW'(HELD_DEPTH));
	assign ret_vel      = (cur_vel_q == '0) ? RETURN_VELOCITY : cur_vel_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (op_valid) begin
					case (op.op)
						OP_NOTE_ON:  state_d = ST_ON_EMIT;
						OP_NOTE_OFF: state_d = ST_OFF_CHECK;
						OP_PEDAL_UP: begin
							if (op.mono && dcnt_q != '0) state_d = ST_RPL_RD;
						end
						OP_ALL_OFF:  state_d = ST_ALL_EMIT;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_ON_EMIT: begin
				if (slot_free) state_d = held_full ? ST_ON_PREP : ST_APPEND;
			end
			ST_ON_PREP: state_d = ST_SHIFT;
			ST_SHIFT: begin
				if (j_last_shift) state_d = ST_DEC;
			end
			ST_DEC:    state_d = on_ctx_q ? ST_APPEND : ST_OFF_TOP;
			ST_APPEND: state_d = ST_IDLE;
			ST_OFF_CHECK: begin
				if (op_q.mono && pedal_q) begin
					state_d = (dcnt_q == '0) ? ST_D_APPEND : ST_D_SRCH;
				end else begin
					state_d = ST_OFF_START;
				end
			end
			ST_D_SRCH: begin
				if (d_hit)       state_d = ST_IDLE;
				else if (dj_top) state_d = ST_D_APPEND;
			end
			ST_D_APPEND:  state_d = ST_IDLE;
			ST_OFF_START: state_d = (hcnt_q == '0) ? ST_OFF_TOP : ST_SRCH;
			ST_SRCH: begin
				if (h_hit)      state_d = j_top ? ST_DEC : ST_SHIFT;
				else if (j_top) state_d = ST_OFF_TOP;
			end
			ST_OFF_TOP: begin
				state_d = (op_q.mono && hcnt_q != '0) ? ST_OFF_RET : ST_OFF_EMIT;
			end
			ST_OFF_RET, ST_OFF_EMIT: begin
				if (slot_free) state_d = rpl_more ? ST_RPL_RD : ST_IDLE;
			end
			ST_RPL_RD:   state_d = ST_RPL_WAIT;
			ST_RPL_WAIT: state_d = ST_OFF_START;
			ST_ALL_EMIT: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory strobes, queue pop and command word
	always_comb begin
		op_ready = (state_q == ST_IDLE);
		h_re     = 1'b0;
		h_raddr  = '0;
		h_we     = 1'b0;
		h_waddr  = j_q;
		h_wdata  = h_rdata_q;
		d_re     = 1'b0;
		d_raddr  = '0;
		d_we     = 1'b0;
		d_waddr  = dcnt_q[DIW-1:0];
		emit_en  = 1'b0;
		emit_res.command          = CMD_START;
		emit_res.channel          = op_q.channel;
		emit_res.target           = cur_note_q;
		emit_res.velocity         = cur_vel_q;
		emit_res.glide_from       = '0;
		emit_res.glide_from_valid = 1'b0;
		emit_res.same_note        = 1'b0;
		emit_res.release_tail     = 1'b0;
		emit_res.last             = last_flag;
		case (state_q)
			ST_ON_EMIT: begin
				emit_en                   = slot_free;
				emit_res.glide_from       = prev_note_q;
				emit_res.glide_from_valid = prev_valid_q;
				if (!op_q.mono) begin
					emit_res.command   = CMD_POLY_ON;
					emit_res.same_note = same_on;
				end else if (op_q.legato && hcnt_q != '0 && !same_on) begin
					emit_res.command = CMD_GLIDE;
				end else begin
					emit_res.same_note = same_on;
				end
			end
			ST_ON_PREP: begin
				h_re    = 1'b1;
				h_raddr = HIW'(1);
			end
			ST_SHIFT: begin
				h_we = 1'b1;
				if (!j_last_shift) begin
					h_re    = 1'b1;
					h_raddr = h_j2[HIW-1:0];
				end
			end
			ST_APPEND: begin
				h_we    = 1'b1;
				h_waddr = hcnt_q[HIW-1:0];
				h_wdata = cur_note_q;
			end
			ST_OFF_CHECK: begin
				d_re = op_q.mono && pedal_q && dcnt_q != '0;
			end
			ST_D_SRCH: begin
				if (!d_hit && !dj_top) begin
					d_re    = 1'b1;
					d_raddr = d_j1[DIW-1:0];
				end
			end
			ST_D_APPEND: begin
				d_we = (dcnt_q < DCW'(DEFERRED_DEPTH));
			end
			ST_OFF_START: begin
				h_re = (hcnt_q != '0);
			end
			ST_SRCH: begin
				if (!j_top) begin
					h_re    = 1'b1;
					h_raddr = h_j1[HIW-1:0];
				end
			end
			ST_OFF_TOP: begin
				h_re    = op_q.mono && hcnt_q != '0;
				h_raddr = HIW'(hcnt_q - HCW'(1));
			end
			ST_OFF_RET: begin
				emit_en           = slot_free;
				emit_res.target   = h_rdata_q;
				emit_res.velocity = ret_vel;
				if (op_q.legato) begin
					emit_res.command          = CMD_GLIDE;
					emit_res.glide_from       = prev_note_q;
					emit_res.glide_from_valid = prev_valid_q;
				end else begin
					emit_res.glide_from       = cur_note_q;
					emit_res.glide_from_valid = 1'b1;
				end
			end
			ST_OFF_EMIT: begin
				emit_en               = slot_free;
				emit_res.command      = op_q.mono ? CMD_RELEASE : CMD_POLY_OFF;
				emit_res.release_tail = cur_tail_q;
			end
			ST_RPL_RD: begin
				d_re    = 1'b1;
				d_raddr = r_q;
			end
			ST_ALL_EMIT: begin
				emit_en               = slot_free;
				emit_res.command      = CMD_ALL_OFF;
				emit_res.target       = '0;
				emit_res.velocity     = '0;
				emit_res.release_tail = cur_tail_q;
			end
			default: ;
		endcase
	end

	// held stack and deferred list storage, registered reads
	always_ff @(posedge clk) begin
		if (h_we) held_mem[h_waddr] <= h_wdata;
		if (h_re) h_rdata_q <= held_mem[h_raddr];
	end

	always_ff @(posedge clk) begin
		if (d_we) def_mem[d_waddr] <= cur_note_q;
		if (d_re) d_rdata_q <= def_mem[d_raddr];
	end

	// control state: counts, pedal, previous note, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			hcnt_q       <= '0;
			dcnt_q       <= '0;
			pedal_q      <= 1'b0;
			prev_note_q  <= '0;
			prev_valid_q <= 1'b0;
			on_ctx_q     <= 1'b0;
			replay_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (op_valid) begin
						replay_q <= (op.op == OP_PEDAL_UP);
						if (op.op == OP_PEDAL_DOWN) begin
							pedal_q <= 1'b1;
						end else if (op.op == OP_PEDAL_UP) begin
							pedal_q <= 1'b0;
							dcnt_q  <= '0;
						end
					end
				end
				ST_ON_EMIT: begin
					on_ctx_q <= 1'b1;
					if (slot_free) begin
						prev_note_q  <= cur_note_q;
						prev_valid_q <= 1'b1;
					end
				end
				ST_DEC:    hcnt_q <= hcnt_q - HCW'(1);
				ST_APPEND: hcnt_q <= hcnt_q + HCW'(1);
				ST_D_APPEND: begin
					if (dcnt_q < DCW'(DEFERRED_DEPTH)) dcnt_q <= dcnt_q + DCW'(1);
				end
				ST_OFF_START: on_ctx_q <= 1'b0;
				ST_OFF_RET: begin
					if (slot_free) begin
						prev_note_q  <= h_rdata_q;
						prev_valid_q <= 1'b1;
					end
				end
				ST_ALL_EMIT: begin
					if (slot_free) begin
						hcnt_q       <= '0;
						dcnt_q       <= '0;
						pedal_q      <= 1'b0;
						prev_note_q  <= '0;
						prev_valid_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers and command word
	always_ff @(posedge clk) begin
		if (emit_en) out_q <= emit_res;
		case (state_q)
			ST_IDLE: begin
				if (op_valid) begin
					op_q       <= op;
					cur_note_q <= op.note;
					cur_vel_q  <= op.velocity;
					cur_tail_q <= op.tail;
					rcnt_q     <= dcnt_q;
					r_q        <= '0;
				end
			end
			ST_ON_PREP:   j_q <= '0;
			ST_SHIFT: begin
				if (!j_last_shift) j_q <= h_j1[HIW-1:0];
			end
			ST_OFF_CHECK: dj_q <= '0;
			ST_D_SRCH: begin
				if (!d_hit && !dj_top) dj_q <= d_j1[DIW-1:0];
			end
			ST_OFF_START: j_q <= '0;
			ST_SRCH: begin
				if (!h_hit && !j_top) j_q <= h_j1[HIW-1:0];
			end
			ST_OFF_RET, ST_OFF_EMIT: begin
				if (slot_free && rpl_more) r_q <= r_1[DIW-1:0];
			end
			ST_RPL_WAIT: begin
				cur_note_q <= d_rdata_q;
				cur_vel_q  <= '0;
				cur_tail_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ===== rtl/mnps_checker.sv =====
// Port-level checks on the command output of the note priority stack,
// bound to the top level. Depends on mnps_pkg and the defines header.
`include "mono_note_priority_stack_defines.svh"

module mnps_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [mnps_pkg::CMD_W-1:0]  command,
	input logic [mnps_pkg::NOTE_W-1:0] target_note,
	input logic [mnps_pkg::VEL_W-1:0]  out_velocity,
	input logic                        glide_from_valid,
	input logic                        same_note,
	input logic                        release_tail,
	input logic                        last
);
	import mnps_pkg::*;

	// hold a stalled word
	`MNPS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(command) && $stable(target_note) && $stable(last))

	// all-off is a single word with no note
	`MNPS_ASSERT_IMP(a_all_off, out_valid && command == CMD_ALL_OFF, last && target_note == '0 && out_velocity == '0)

	// releases carry no portamento source
	`MNPS_ASSERT_IMP(a_release, out_valid && (command == CMD_RELEASE || command == CMD_POLY_OFF), !glide_from_valid && !same_note)

	// starts and glides never tail off, glides never repeat
	`MNPS_ASSERT_IMP(a_start_glide, out_valid && (command == CMD_START || command == CMD_GLIDE), !release_tail && !(command == CMD_GLIDE && same_note))

endmodule

bind mono_note_priority_stack mnps_checker u_mnps_checker (.*);

// ===== dv/tb.sv =====
// Testbench for mono_note_priority_stack: queued event driver, command monitor and a
// cycle-free predictor of the note stack, deferred note-offs and last-note priority.
// Depends on mnps_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;
	import mnps_pkg::*;

	localparam logic [KIND_W-1:0] KIND_ALL_OFF = 2'd3;
	localparam int HELD_MAX    = HELD_DEPTH_DEF;
	localparam int DEFER_MAX   = DEFERRED_DEPTH_DEF;
	localparam int MAX_CMDS    = 16;
	localparam int SETTLE_CYC  = 200;
	localparam int HOLD_CYC    = 400;
	localparam int IDLE_PCT    = 35;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CH_W-1:0]   channel;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  velocity;
		logic              tail;
		logic              pedal;
	} midi_ev_t;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   cfg_valid  = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index  = '0;
	logic                   cfg_data   = 1'b0;
	logic                   in_valid   = 1'b0;
	logic                   in_ready;
	logic [KIND_W-1:0]      kind       = '0;
	logic [CH_W-1:0]        channel    = '0;
	logic [NOTE_W-1:0]      note       = '0;
	logic [VEL_W-1:0]       velocity   = '0;
	logic                   tail_off   = 1'b0;
	logic                   pedal_down = 1'b0;
	logic                   out_valid;
	logic                   out_ready  = 1'b0;
	logic [CMD_W-1:0]       command;
	logic [CH_W-1:0]        out_channel;
	logic [NOTE_W-1:0]      target_note;
	logic [VEL_W-1:0]       out_velocity;
	logic [NOTE_W-1:0]      glide_from_note;
	logic                   glide_from_valid;
	logic                   same_note;
	logic                   release_tail;
	logic                   last;

	mono_note_priority_stack dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .channel(channel), .note(note),
		.velocity(velocity), .tail_off(tail_off), .pedal_down(pedal_down),
		.out_valid(out_valid), .out_ready(out_ready), .command(command),
		.out_channel(out_channel), .target_note(target_note), .out_velocity(out_velocity),
		.glide_from_note(glide_from_note), .glide_from_valid(glide_from_valid),
		.same_note(same_note), .release_tail(release_tail), .last(last)
	);

	// Stimulus and scoreboard state
	midi_ev_t ev_pend_q[$];
	res_t     voice_q[$];
	int       fail_cnt  = 0;
	int       acc_cnt   = 0;
	int       drv_seen  = 0;
	bit       steady    = 1'b0;
	bit       hold_req  = 1'b0;
	bit       hold_done = 1'b0;
	int       hold_left = 0;

	// Shadow of the note stack and configuration
	logic [NOTE_W-1:0] held_notes [HELD_MAX];
	logic [NOTE_W-1:0] defer_notes [DEFER_MAX];
	int                held_n     = 0;
	int                defer_n    = 0;
	int                burst_n    = 0;
	logic              pedal_on   = 1'b0;
	logic              mdl_mono   = 1'b0;
	logic              mdl_legato = 1'b0;
	logic [NOTE_W-1:0] last_note  = '0;
	logic              last_valid = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("tb: failure");
		$finish;
	end

	// Queue one expected voice command, capped per event
	task automatic push_cmd(cmd_t c, logic [CH_W-1:0] ch, logic [NOTE_W-1:0] tgt,
			logic [VEL_W-1:0] vel, logic [NOTE_W-1:0] gfn, logic gfv, logic same,
			logic tl);
		res_t r;
		if (burst_n < MAX_CMDS) begin
			r.command          = c;
			r.channel          = ch;
			r.target           = tgt;
			r.velocity         = vel;
			r.glide_from       = gfn;
			r.glide_from_valid = gfv;
			r.same_note        = same;
			r.release_tail     = tl;
			r.last             = 1'b0;
			voice_q.insert(voice_q.size(), r);
			burst_n++;
		end
	endtask

	// Note off: defer under pedal in mono, else drop from stack and return or release
	task automatic note_release(logic [CH_W-1:0] ch, logic [NOTE_W-1:0] nt,
			logic [VEL_W-1:0] vel, logic tl);
		int i;
		bit hit;
		logic [NOTE_W-1:0] ret;
		logic [VEL_W-1:0] rv;
		hit = 1'b0;
		if (mdl_mono && pedal_on) begin
			for (i = 0; i < defer_n; i++)
				if (defer_notes[i] == nt)
					hit = 1'b1;
			if (!hit && defer_n < DEFER_MAX) begin
				defer_notes[defer_n] = nt;
				defer_n++;
			end
		end else begin
			for (i = 0; i < held_n; i++) begin
				if (!hit && held_notes[i] == nt)
					hit = 1'b1;
				if (hit && i < held_n - 1)
					held_notes[i] = held_notes[i + 1];
			end
			if (hit)
				held_n--;
			if (mdl_mono && held_n > 0) begin
				ret = held_notes[held_n - 1];
				rv  = (vel != 0) ? vel : RETURN_VELOCITY;
				if (mdl_legato)
					push_cmd(CMD_GLIDE, ch, ret, rv, last_note, last_valid, 1'b0, 1'b0);
				else
					push_cmd(CMD_START, ch, ret, rv, nt, 1'b1, 1'b0, 1'b0);
				last_note  = ret;
				last_valid = 1'b1;
			end else if (mdl_mono) begin
				push_cmd(CMD_RELEASE, ch, nt, vel, '0, 1'b0, 1'b0, tl);
			end else begin
				push_cmd(CMD_POLY_OFF, ch, nt, vel, '0, 1'b0, 1'b0, tl);
			end
		end
	endtask

	// Advance the shadow state by one accepted event word and queue its commands
	task automatic track_event(midi_ev_t ev);
		logic same;
		logic [NOTE_W-1:0] snap [DEFER_MAX];
		int cnt, i;
		burst_n = 0;
		case (ev.kind)
			KIND_NOTE_ON: begin
				same = last_valid && (ev.note == last_note);
				if (mdl_mono) begin
					if (mdl_legato && held_n > 0 && !same)
						push_cmd(CMD_GLIDE, ev.channel, ev.note, ev.velocity, last_note,
							last_valid, 1'b0, 1'b0);
					else
						push_cmd(CMD_START, ev.channel, ev.note, ev.velocity, last_note,
							last_valid, same, 1'b0);
				end else begin
					push_cmd(CMD_POLY_ON, ev.channel, ev.note, ev.velocity, last_note,
						last_valid, same, 1'b0);
				end
				last_note  = ev.note;
				last_valid = 1'b1;
				// drop the oldest entry when full
				if (held_n >= HELD_MAX) begin
					for (i = 0; i < HELD_MAX - 1; i++)
						held_notes[i] = held_notes[i + 1];
					held_n = HELD_MAX - 1;
				end
				held_notes[held_n] = ev.note;
				held_n++;
			end
			KIND_NOTE_OFF: note_release(ev.channel, ev.note, ev.velocity, ev.tail);
			KIND_PEDAL: begin
				pedal_on = ev.pedal;
				// replay deferred note-offs on release in mono, else just forget them
				if (!ev.pedal && mdl_mono) begin
					cnt     = defer_n;
					snap    = defer_notes;
					defer_n = 0;
					for (i = 0; i < cnt; i++)
						note_release(ev.channel, snap[i], '0, 1'b1);
				end else if (!ev.pedal) begin
					defer_n = 0;
				end
			end
			default: begin
				push_cmd(CMD_ALL_OFF, ev.channel, '0, '0, '0, 1'b0, 1'b0, ev.tail);
				held_n     = 0;
				defer_n    = 0;
				pedal_on   = 1'b0;
				last_note  = '0;
				last_valid = 1'b0;
			end
		endcase
		// mark the final command of this event
		if (burst_n > 0)
			voice_q[voice_q.size() - 1].last = 1'b1;
	endtask

	task automatic check_field(string fname, int want, int got);
		if (want != got) begin
			$display("[%0t] %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
			fail_cnt++;
		end
	endtask

	// Capture accepted event and register words at the rising edge
	always @(posedge clk) begin : capture
		midi_ev_t ev;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MONO_ENABLE)
					mdl_mono = cfg_data;
				else if (cfg_index == REG_LEGATO_ENABLE)
					mdl_legato = cfg_data;
			end
			if (in_valid && in_ready) begin
				ev.kind     = kind;
				ev.channel  = channel;
				ev.note     = note;
				ev.velocity = velocity;
				ev.tail     = tail_off;
				ev.pedal    = pedal_down;
				track_event(ev);
				acc_cnt++;
			end
		end
	end

	// Compare each accepted command word against the oldest expectation
	always @(posedge clk) begin : monitor
		res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (voice_q.size() == 0) begin
				$display("[%0t] unexpected command word: expected none, actual cmd %0d note %0d",
					$time, command, target_note);
				fail_cnt++;
			end else begin
				e = voice_q.pop_front();
				check_field("command", int'(e.command), int'(command));
				check_field("out_channel", int'(e.channel), int'(out_channel));
				check_field("target_note", int'(e.target), int'(target_note));
				check_field("out_velocity", int'(e.velocity), int'(out_velocity));
				check_field("glide_from_note", int'(e.glide_from), int'(glide_from_note));
				check_field("glide_from_valid", int'(e.glide_from_valid),
					int'(glide_from_valid));
				check_field("same_note", int'(e.same_note), int'(same_note));
				check_field("release_tail", int'(e.release_tail), int'(release_tail));
				check_field("last", int'(e.last), int'(last));
			end
		end
	end

	// Drive the next event word at the falling edge, with random gaps outside the steady phase
	always @(negedge clk) begin : driver
		midi_ev_t ev;
		if (!in_valid || acc_cnt != drv_seen) begin
			drv_seen = acc_cnt;
			if (arst_n && ev_pend_q.size() != 0 &&
					(steady || $urandom_range(99) >= IDLE_PCT)) begin
				ev = ev_pend_q.pop_front();
				kind       <= ev.kind;
				channel    <= ev.channel;
				note       <= ev.note;
				velocity   <= ev.velocity;
				tail_off   <= ev.tail;
				pedal_down <= ev.pedal;
				in_valid   <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls outside the steady phase, plus one long hold-off on request
	always @(negedge clk) begin : receiver
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYC - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic send_ev(logic [KIND_W-1:0] k, logic [CH_W-1:0] ch, logic [NOTE_W-1:0] nt,
			logic [VEL_W-1:0] vel, logic tl, logic pd);
		midi_ev_t ev;
		ev.kind     = k;
		ev.channel  = ch;
		ev.note     = nt;
		ev.velocity = vel;
		ev.tail     = tl;
		ev.pedal    = pd;
		ev_pend_q.insert(ev_pend_q.size(), ev);
	endtask

	// Wait until every word is out and nothing is expected, then let the block settle
	task automatic wait_drain();
		do @(posedge clk);
		while (ev_pend_q.size() != 0 || in_valid || voice_q.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_mode(logic mono, logic legato);
		wait_drain();
		write_reg(REG_MONO_ENABLE, mono);
		write_reg(REG_LEGATO_ENABLE, legato);
	endtask

	// Mostly well-formed playing over a small note pool, with some raw noise
	task automatic play_phrase(int n);
		logic [NOTE_W-1:0] pool [6];
		int i, r;
		for (i = 0; i < 6; i++)
			pool[i] = NOTE_W'($urandom_range(127));
		for (i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 40)
				send_ev(KIND_NOTE_ON, CH_W'($urandom_range(15)), pool[$urandom_range(5)],
					VEL_W'($urandom_range(127)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			else if (r < 70)
				send_ev(KIND_NOTE_OFF, CH_W'($urandom_range(15)), pool[$urandom_range(5)],
					VEL_W'(($urandom_range(3) == 0) ? 0 : $urandom_range(127)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			else if (r < 78)
				send_ev(KIND_PEDAL, CH_W'($urandom_range(15)), NOTE_W'($urandom_range(127)),
					VEL_W'($urandom_range(127)), 1'($urandom_range(1)), 1'b1);
			else if (r < 86)
				send_ev(KIND_PEDAL, CH_W'($urandom_range(15)), NOTE_W'($urandom_range(127)),
					VEL_W'($urandom_range(127)), 1'($urandom_range(1)), 1'b0);
			else if (r < 90)
				send_ev(KIND_ALL_OFF, CH_W'($urandom_range(15)),
					NOTE_W'($urandom_range(127)), VEL_W'($urandom_range(127)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			else
				send_ev(KIND_W'($urandom_range(3)), CH_W'($urandom_range(15)),
					NOTE_W'($urandom_range(127)), VEL_W'($urandom_range(127)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
		end
	endtask

	// Overflow the held stack, then send three note-offs for random notes
	task automatic stack_flood();
		int i;
		for (i = 0; i < HELD_MAX + 2; i++)
			send_ev(KIND_NOTE_ON, CH_W'($urandom_range(15)), NOTE_W'($urandom_range(127)),
				VEL_W'($urandom_range(127)), 1'b0, 1'b0);
		for (i = 0; i < 3; i++)
			send_ev(KIND_NOTE_OFF, CH_W'($urandom_range(15)), NOTE_W'($urandom_range(127)),
				'0, 1'b1, 1'b0);
	endtask

	// Overflow the deferred list under pedal, with a duplicate, then release it
	task automatic pedal_flood();
		logic [NOTE_W-1:0] base;
		int i;
		base = NOTE_W'($urandom_range(127));
		send_ev(KIND_NOTE_ON, CH_W'($urandom_range(15)), base, VEL_W'($urandom_range(127)),
			1'b0, 1'b0);
		send_ev(KIND_PEDAL, CH_W'($urandom_range(15)), '0, '0, 1'b0, 1'b1);
		for (i = 0; i < DEFER_MAX + 2; i++)
			send_ev(KIND_NOTE_OFF, CH_W'($urandom_range(15)), NOTE_W'(base + i),
				VEL_W'($urandom_range(127)), 1'($urandom_range(1)), 1'b0);
		send_ev(KIND_NOTE_OFF, CH_W'($urandom_range(15)), base, '0, 1'b0, 1'b0);
		send_ev(KIND_PEDAL, CH_W'($urandom_range(15)), '0, '0, 1'b0, 1'b0);
	endtask

	initial begin : stimulus
		logic [1:0] mode_tbl [6];
		int p;
		mode_tbl[0] = 2'b10;
		mode_tbl[1] = 2'b11;
		mode_tbl[2] = 2'b00;
		mode_tbl[3] = 2'b11;
		mode_tbl[4] = 2'b01;
		mode_tbl[5] = 2'b10;

		// hold reset, release away from the rising edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// mono retrigger: repeat, return with zero velocity, release, unknown note, pedal
		set_mode(1'b1, 1'b0);
		send_ev(KIND_NOTE_ON, 4'd0, 7'd60, 7'd100, 1'b0, 1'b0);
		send_ev(KIND_NOTE_ON, 4'd0, 7'd60, 7'd127, 1'b0, 1'b0);
		send_ev(KIND_NOTE_ON, 4'd15, 7'd64, 7'd0, 1'b0, 1'b0);
		send_ev(KIND_NOTE_OFF, 4'd15, 7'd64, 7'd0, 1'b0, 1'b0);
		send_ev(KIND_NOTE_OFF, 4'd3, 7'd60, 7'd127, 1'b1, 1'b0);
		send_ev(KIND_NOTE_OFF, 4'd3, 7'd10, 7'd1, 1'b0, 1'b0);
		send_ev(KIND_PEDAL, 4'd1, 7'd0, 7'd0, 1'b0, 1'b1);
		send_ev(KIND_NOTE_ON, 4'd1, 7'd72, 7'd90, 1'b0, 1'b1);
		send_ev(KIND_NOTE_OFF, 4'd1, 7'd72, 7'd90, 1'b0, 1'b1);
		send_ev(KIND_NOTE_OFF, 4'd1, 7'd72, 7'd90, 1'b0, 1'b1);
		send_ev(KIND_PEDAL, 4'd2, 7'd127, 7'd127, 1'b1, 1'b0);

		// mono legato: glide up, glide back on release, then release and all off
		set_mode(1'b1, 1'b1);
		send_ev(KIND_NOTE_ON, 4'd5, 7'd0, 7'd1, 1'b0, 1'b0);
		send_ev(KIND_NOTE_ON, 4'd5, 7'd127, 7'd127, 1'b0, 1'b0);
		send_ev(KIND_NOTE_OFF, 4'd5, 7'd127, 7'd5, 1'b0, 1'b0);
		send_ev(KIND_NOTE_OFF, 4'd5, 7'd0, 7'd64, 1'b1, 1'b0);
		send_ev(KIND_NOTE_ON, 4'd9, 7'd33, 7'd70, 1'b0, 1'b0);
		send_ev(KIND_ALL_OFF, 4'd15, 7'd127, 7'd127, 1'b1, 1'b1);

		// poly forwarding: pedal does not defer, release only forgets
		set_mode(1'b0, 1'b0);
		send_ev(KIND_NOTE_ON, 4'd15, 7'd127, 7'd127, 1'b0, 1'b0);
		send_ev(KIND_NOTE_ON, 4'd15, 7'd127, 7'd0, 1'b0, 1'b0);
		send_ev(KIND_PEDAL, 4'd0, 7'd0, 7'd0, 1'b0, 1'b1);
		send_ev(KIND_NOTE_OFF, 4'd0, 7'd127, 7'd0, 1'b1, 1'b0);
		send_ev(KIND_PEDAL, 4'd0, 7'd0, 7'd0, 1'b0, 1'b0);
		send_ev(KIND_ALL_OFF, 4'd0, 7'd0, 7'd0, 1'b0, 1'b0);

		// random phases over the mode table, overflowing the stores in the first ones
		for (p = 0; p < 6; p++) begin
			set_mode(mode_tbl[p][1], mode_tbl[p][0]);
			steady   = (p == 3);
			hold_req = (p == 1);
			play_phrase(14);
			if (p < 3) begin
				if (mode_tbl[p][1])
					pedal_flood();
				else
					stack_flood();
			end
		end

		wait_drain();
		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== mono_note_priority_stack.f =====
+incdir+rtl
rtl/mnps_pkg.sv
rtl/mnps_front.sv
rtl/mnps_queue.sv
rtl/mnps_back.sv
rtl/mono_note_priority_stack.sv
rtl/mnps_checker.sv
dv/tb.sv
